// File: rtl/core/assert_macros.svh
// assertion macros used by the top level of the header classifier
// each macro samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FHSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FHSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/fhsc_pkg.sv
// types, constants, signatures and microcode program of the header classifier
// no dependencies; used by the engine and the top level
`timescale 1ns / 1ps

package fhsc_pkg;

  // header storage geometry
  localparam int HEADER_BYTES = 128;
  localparam int ADDR_W       = $clog2(HEADER_BYTES);
  localparam int CNT_W        = $clog2(HEADER_BYTES + 1);

  // microcode geometry
  localparam int PC_W  = 4;
  localparam int IDX_W = 4;

  // register reset
  localparam logic [15:0] SUPPORT_MAP_RST = 16'd322;

  // format codes
  localparam logic [2:0] FMT_UNKNOWN  = 3'd0;
  localparam logic [2:0] FMT_ONE_2003 = 3'd1;
  localparam logic [2:0] FMT_TOC_2003 = 3'd2;
  localparam logic [2:0] FMT_ONE_2010 = 3'd3;
  localparam logic [2:0] FMT_TOC_2010 = 3'd4;
  localparam logic [2:0] FMT_CAB      = 3'd5;
  localparam logic [2:0] FMT_ONE_PS   = 3'd6;
  localparam logic [2:0] FMT_TOC_PS   = 3'd7;

  // fixed header offsets
  localparam int OFF_CAB_HEAD = 'h00;
  localparam int OFF_CAB_VER  = 'h24;
  localparam int OFF_FMT_GUID = 'h30;
  localparam int OFF_FTYPE    = 'h00;
  localparam int OFF_LEGACY   = 'h20;
  localparam int OFF_FFV      = 'h40;
  localparam int OFF_VAR      = 'h48;

  // signatures, byte 0 in the top byte, shorter ones left aligned
  localparam logic [127:0] SIG_V_CAB_HEAD = {32'h4D534346, 96'h0};
  localparam logic [127:0] SIG_V_CAB_VER  = {16'h0301, 112'h0};
  localparam logic [127:0] SIG_V_RS_ONE   = 128'he4525c7b8cd8a74daeb15378d02996d3;
  localparam logic [127:0] SIG_V_RS_TOC   = 128'ha12fff43d9ef764c9ee210ea5722765f;
  localparam logic [127:0] SIG_V_RS_FMT   = 128'h3fdd9a101b91f549a5d01791edc8aed8;
  localparam logic [127:0] SIG_V_PS_FMT   = 128'h2fe98d63d4a6c14b9a36b3fc2511a5b7;
  localparam logic [127:0] SIG_V_PS_ONE   = 128'hb47c931f6fb25f44b9f817e20160e461;
  localparam logic [127:0] SIG_V_PS_TOC   = 128'h38fddbe4c7e58b40a8a10e7b421e1f5f;
  localparam logic [127:0] SIG_V_FFV_LEG  = {32'h09000000, 96'h0};
  localparam logic [127:0] SIG_V_FFV_ONE  = {32'h2a000000, 96'h0};
  localparam logic [127:0] SIG_V_FFV_TOC  = {32'h1b000000, 96'h0};

  // signature select, also the index of its match flag
  typedef enum logic [3:0] {
    SIG_CAB_HEAD,
    SIG_CAB_VER,
    SIG_RS_FMT,
    SIG_PS_FMT,
    SIG_RS_ONE,
    SIG_RS_TOC,
    SIG_ZERO,
    SIG_FFV_ONE,
    SIG_FFV_TOC,
    SIG_FFV_LEG,
    SIG_PS_ONE,
    SIG_PS_TOC
  } sig_e;

  localparam int NUM_SIG = 12;

  // microcode operations
  typedef enum logic [1:0] {
    OP_CMP,
    OP_JNPS,
    OP_LDOFF,
    OP_DONE
  } op_e;

  // engine states
  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } state_e;

  // one control word
  typedef struct packed {
    op_e                op;
    sig_e               sig;
    logic               rel;
    logic [ADDR_W-1:0]  base;
    logic [IDX_W-1:0]   last_idx;
    logic [PC_W-1:0]    target;
  } uword_t;

  // byte feed from the input channel into the engine
  typedef struct packed {
    logic       acc;
    logic [7:0] data;
    logic       last;
  } feed_t;

  // classification result from the engine
  typedef struct packed {
    logic       valid;
    logic [2:0] code;
  } res_t;

  localparam logic [PC_W-1:0] PC_DONE = PC_W'(14);

  // compare word over a run of bytes
  function automatic uword_t ucmp(sig_e sig, logic rel, int base, int len);
    uword_t w;
    w.op       = OP_CMP;
    w.sig      = sig;
    w.rel      = rel;
    w.base     = ADDR_W'(base);
    w.last_idx = IDX_W'(len - 1);
    w.target   = '0;
    return w;
  endfunction

  // program store
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_DONE, sig: SIG_CAB_HEAD, rel: 1'b0, base: '0, last_idx: '0, target: '0};
    unique case (pc)
      PC_W'(0):  w = ucmp(SIG_CAB_HEAD, 1'b0, OFF_CAB_HEAD, 4);
      PC_W'(1):  w = ucmp(SIG_CAB_VER,  1'b0, OFF_CAB_VER,  2);
      PC_W'(2):  w = ucmp(SIG_RS_FMT,   1'b0, OFF_FMT_GUID, 16);
      PC_W'(3):  w = ucmp(SIG_PS_FMT,   1'b0, OFF_FMT_GUID, 16);
      PC_W'(4):  w = ucmp(SIG_RS_ONE,   1'b0, OFF_FTYPE,    16);
      PC_W'(5):  w = ucmp(SIG_RS_TOC,   1'b0, OFF_FTYPE,    16);
      PC_W'(6):  w = ucmp(SIG_ZERO,     1'b0, OFF_LEGACY,   16);
      PC_W'(7):  w = ucmp(SIG_FFV_ONE,  1'b0, OFF_FFV,      4);
      PC_W'(8):  w = ucmp(SIG_FFV_TOC,  1'b0, OFF_FFV,      4);
      PC_W'(9):  w = ucmp(SIG_FFV_LEG,  1'b0, OFF_FFV,      4);
      PC_W'(10): begin
        w.op     = OP_JNPS;
        w.target = PC_DONE;
      end
      PC_W'(11): begin
        w.op   = OP_LDOFF;
        w.base = ADDR_W'(OFF_VAR);
      end
      PC_W'(12): w = ucmp(SIG_PS_ONE,   1'b1, 0,            16);
      PC_W'(13): w = ucmp(SIG_PS_TOC,   1'b1, 0,            16);
      default:   w.op = OP_DONE;
    endcase
    return w;
  endfunction

  // reference byte of a signature
  function automatic logic [7:0] sig_byte(sig_e sig, logic [IDX_W-1:0] idx);
    logic [127:0] v;
    unique case (sig)
      SIG_CAB_HEAD: v = SIG_V_CAB_HEAD;
      SIG_CAB_VER:  v = SIG_V_CAB_VER;
      SIG_RS_FMT:   v = SIG_V_RS_FMT;
      SIG_PS_FMT:   v = SIG_V_PS_FMT;
      SIG_RS_ONE:   v = SIG_V_RS_ONE;
      SIG_RS_TOC:   v = SIG_V_RS_TOC;
      SIG_FFV_ONE:  v = SIG_V_FFV_ONE;
      SIG_FFV_TOC:  v = SIG_V_FFV_TOC;
      SIG_FFV_LEG:  v = SIG_V_FFV_LEG;
      SIG_PS_ONE:   v = SIG_V_PS_ONE;
      SIG_PS_TOC:   v = SIG_V_PS_TOC;
      default:      v = '0;
    endcase
    return v[{~idx, 3'b000} +: 8];
  endfunction

  // offset of the package file-type guid from the variable-width byte
  function automatic logic [ADDR_W-1:0] var_offset(logic [7:0] w);
    logic [ADDR_W-1:0] off;
    if (w == 8'h00) begin
      off = ADDR_W'(OFF_VAR + 1);
    end else if ((w & 8'h07) == 8'h04) begin
      off = ADDR_W'(OFF_VAR + 17);
    end else if ((w & 8'h3F) == 8'h20) begin
      off = ADDR_W'(OFF_VAR + 18);
    end else if ((w & 8'h7F) == 8'h40) begin
      off = ADDR_W'(OFF_VAR + 19);
    end else if (w == 8'h80) begin
      off = ADDR_W'(OFF_VAR + 21);
    end else begin
      off = ADDR_W'(OFF_VAR);
    end
    return off;
  endfunction

  // final decision over the match flags
  function automatic logic [2:0] classify(logic [NUM_SIG-1:0] f);
    logic [2:0] code;
    logic       legacy;
    code   = FMT_UNKNOWN;
    legacy = !f[SIG_ZERO];
    if (f[SIG_CAB_HEAD] && f[SIG_CAB_VER]) begin
      code = FMT_CAB;
    end else if (f[SIG_RS_FMT]) begin
      if (f[SIG_RS_ONE] && legacy && f[SIG_FFV_LEG]) begin
        code = FMT_ONE_2003;
      end else if (f[SIG_RS_ONE] && !legacy && f[SIG_FFV_ONE]) begin
        code = FMT_ONE_2010;
      end else if (f[SIG_RS_TOC] && legacy && f[SIG_FFV_LEG]) begin
        code = FMT_TOC_2003;
      end else if (f[SIG_RS_TOC] && !legacy && f[SIG_FFV_TOC]) begin
        code = FMT_TOC_2010;
      end
    end else if (f[SIG_PS_FMT] && f[SIG_RS_ONE]) begin
      if (f[SIG_PS_ONE]) begin
        code = FMT_ONE_PS;
      end else if (f[SIG_PS_TOC]) begin
        code = FMT_TOC_PS;
      end
    end
    return code;
  endfunction

endpackage

// File: rtl/core/fhsc_if.sv
// valid/ready channel interfaces of the header classifier
// depends on nothing; payload widths are fixed by the byte and result formats
`timescale 1ns / 1ps

// byte input channel
interface fhsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// result output channel
interface fhsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] format_code;
  logic [1:0] support_class;

  modport source (output valid, output format_code, output support_class, input ready);
  modport sink   (input valid, input format_code, input support_class, output ready);
endinterface

// File: rtl/core/fhsc_engine.sv
// header store and microcoded compare sequencer of the header classifier
// depends on fhsc_pkg for the program, signatures, types and decision
`timescale 1ns / 1ps

module fhsc_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fhsc_pkg::feed_t feed_i,
  input  logic            slot_free_i,
  output logic            idle_o,
  output fhsc_pkg::res_t  res_o
);

  fhsc_pkg::state_e                   st_q, st_d;
  logic [fhsc_pkg::PC_W-1:0]          pc_q, pc_d;
  logic [fhsc_pkg::IDX_W-1:0]         idx_q, idx_d;
  logic [fhsc_pkg::CNT_W-1:0]         count_q, count_d;
  logic [fhsc_pkg::NUM_SIG-1:0]       flags_q, flags_d;
  logic                               ld_v_q, ld_v_d;
  logic [fhsc_pkg::ADDR_W-1:0]        off_q, off_d;
  logic                               cmp_v_q, cmp_v_d;
  fhsc_pkg::sig_e                     cmp_sig_q, cmp_sig_d;
  logic [7:0]                         cmp_ref_q, cmp_ref_d;
  logic                               cmp_in_q, cmp_in_d;

  logic [7:0]                         mem_q [fhsc_pkg::HEADER_BYTES];
  logic [7:0]                         rdata_q;

  fhsc_pkg::uword_t                   uw;
  logic [fhsc_pkg::ADDR_W-1:0]        rd_addr;
  logic                               rd_en;
  logic                               in_range;
  logic                               mem_we;
  logic [7:0]                         hdr_byte;

  // current control word and its read address
  assign uw       = fhsc_pkg::ucode(pc_q);
  assign rd_addr  = (uw.rel ? off_q : uw.base) + fhsc_pkg::ADDR_W'(idx_q);
  assign in_range = fhsc_pkg::CNT_W'(rd_addr) < count_q;
  assign idle_o   = (st_q == fhsc_pkg::ST_LOAD);

  // bytes past the end of a short file read as zero
  assign hdr_byte = cmp_in_q ? rdata_q : 8'h00;

  assign mem_we = (st_q == fhsc_pkg::ST_LOAD) && feed_i.acc &&
                  (count_q < fhsc_pkg::CNT_W'(fhsc_pkg::HEADER_BYTES));

  // header store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[fhsc_pkg::ADDR_W-1:0]] <= feed_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // sequencer and compare pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= fhsc_pkg::ST_LOAD;
      pc_q      <= '0;
      idx_q     <= '0;
      count_q   <= '0;
      flags_q   <= '0;
      ld_v_q    <= 1'b0;
      off_q     <= '0;
      cmp_v_q   <= 1'b0;
      cmp_sig_q <= fhsc_pkg::SIG_CAB_HEAD;
      cmp_ref_q <= '0;
      cmp_in_q  <= 1'b0;
    end else begin
      st_q      <= st_d;
      pc_q      <= pc_d;
      idx_q     <= idx_d;
      count_q   <= count_d;
      flags_q   <= flags_d;
      ld_v_q    <= ld_v_d;
      off_q     <= off_d;
      cmp_v_q   <= cmp_v_d;
      cmp_sig_q <= cmp_sig_d;
      cmp_ref_q <= cmp_ref_d;
      cmp_in_q  <= cmp_in_d;
    end
  end

  // next state, microcode execution and compare stage
  always_comb begin
    st_d      = st_q;
    pc_d      = pc_q;
    idx_d     = idx_q;
    count_d   = count_q;
    flags_d   = flags_q;
    ld_v_d    = ld_v_q;
    off_d     = off_q;
    cmp_v_d   = 1'b0;
    cmp_sig_d = cmp_sig_q;
    cmp_ref_d = cmp_ref_q;
    cmp_in_d  = cmp_in_q;
    rd_en     = 1'b0;
    res_o     = '0;

    // compare stage clears the flag on any mismatching byte
    if (cmp_v_q && (hdr_byte != cmp_ref_q)) begin
      flags_d[cmp_sig_q] = 1'b0;
    end

    unique case (st_q)
      fhsc_pkg::ST_LOAD: begin
        if (feed_i.acc) begin
          if (mem_we) begin
            count_d = count_q + fhsc_pkg::CNT_W'(1);
          end
          if (feed_i.last) begin
            st_d    = fhsc_pkg::ST_RUN;
            pc_d    = '0;
            idx_d   = '0;
            flags_d = '1;
            ld_v_d  = 1'b0;
          end
        end
      end
      fhsc_pkg::ST_RUN: begin
        unique case (uw.op)
          fhsc_pkg::OP_CMP: begin
            rd_en     = 1'b1;
            cmp_v_d   = 1'b1;
            cmp_sig_d = uw.sig;
            cmp_ref_d = fhsc_pkg::sig_byte(uw.sig, idx_q);
            cmp_in_d  = in_range;
            if (idx_q == uw.last_idx) begin
              idx_d = '0;
              pc_d  = pc_q + fhsc_pkg::PC_W'(1);
            end else begin
              idx_d = idx_q + fhsc_pkg::IDX_W'(1);
            end
          end
          fhsc_pkg::OP_JNPS: begin
            // wait for the last compare to land before testing flags
            if (!cmp_v_q) begin
              if (!(flags_q[fhsc_pkg::SIG_PS_FMT] && flags_q[fhsc_pkg::SIG_RS_ONE])) begin
                pc_d = uw.target;
              end else begin
                pc_d = pc_q + fhsc_pkg::PC_W'(1);
              end
            end
          end
          fhsc_pkg::OP_LDOFF: begin
            if (!ld_v_q) begin
              rd_en    = 1'b1;
              cmp_in_d = in_range;
              ld_v_d   = 1'b1;
            end else begin
              off_d  = fhsc_pkg::var_offset(hdr_byte);
              ld_v_d = 1'b0;
              pc_d   = pc_q + fhsc_pkg::PC_W'(1);
            end
          end
          fhsc_pkg::OP_DONE: begin
            if (!cmp_v_q && slot_free_i) begin
              res_o.valid = 1'b1;
              res_o.code  = fhsc_pkg::classify(flags_q);
              st_d        = fhsc_pkg::ST_LOAD;
              count_d     = '0;
            end
          end
          default: st_d = fhsc_pkg::ST_LOAD;
        endcase
      end
      default: st_d = fhsc_pkg::ST_LOAD;
    endcase
  end

endmodule

// File: rtl/core/file_header_signature_classifier_top.sv
// top level of the file header signature classifier
// depends on fhsc_pkg, fhsc_if, fhsc_engine and assert_macros.svh
//
//   channel  | dir | payload                        | transfer
//   ---------+-----+--------------------------------+-------------------
//   in_i     | in  | data_byte[7:0], last           | valid && ready
//   out_o    | out | format_code[2:0], support_class| valid && ready
//   cfg      | in  | cfg_wdata_i[15:0]              | cfg_we_i
//
// bytes are taken one per cycle while the engine is idle; the first 128 are kept
// after the last byte the microcode walks the header store, one read per compare
// step, plus one read of the variable-width byte when the package-store type guid is sought
// the result sits in an output register; a new file streams in while it waits
// the walk's last step stalls while that register still holds an untaken result
// rst_ni clears control state at once; the header store needs no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module file_header_signature_classifier_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  fhsc_in_if.sink       in_i,
  fhsc_out_if.source    out_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);

  logic [15:0]     map_q;
  logic            out_v_q;
  logic [2:0]      code_q;
  logic [1:0]      class_q;
  logic            eng_idle;
  logic            slot_free;
  fhsc_pkg::feed_t feed;
  fhsc_pkg::res_t  res;

  // input transfer into the engine
  assign in_i.ready = eng_idle;
  assign feed.acc   = in_i.valid && in_i.ready;
  assign feed.data  = in_i.data_byte;
  assign feed.last  = in_i.last;

  assign slot_free = !out_v_q || out_o.ready;

  fhsc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .feed_i      (feed),
    .slot_free_i (slot_free),
    .idle_o      (eng_idle),
    .res_o       (res)
  );

  // support map register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= fhsc_pkg::SUPPORT_MAP_RST;
    end else if (cfg_we_i) begin
      map_q <= cfg_wdata_i;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res.valid) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // output register payload, map lookup on load
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      code_q  <= res.code;
      class_q <= map_q[{res.code, 1'b0} +: 2];
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.format_code   = code_q;
  assign out_o.support_class = class_q;

  // checks
  `FHSC_ASSERT_IMP(a_res_slot_free, res.valid, (!out_v_q || out_o.ready), "result with output slot busy")
  `FHSC_ASSERT_NXT(a_busy_after_last, (in_i.valid && in_i.ready && in_i.last), !in_i.ready, "input open during walk")
  `FHSC_ASSERT_IMP(a_res_not_idle, res.valid, !eng_idle, "result while engine idle")

endmodule
